// ===== sv/b32e_pkg.sv =====
// Package for the streaming Base32 encoder: payload structs, the queue command
// type, the alphabet and padding lookups. Used by every module of the encoder.
// No dependencies.
package b32e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } char_item_t;

  // One classified byte: the characters it causes, described for the back end.
  typedef struct packed {
    logic [4:0] sym0;
    logic [4:0] sym1;
    logic       two_syms;
    logic       has_flush;
    logic [4:0] flush_sym;
    logic [2:0] last_idx;
    logic       msg_end;
  } cmd_t;

  localparam int unsigned CMD_QUEUE_DEPTH = 2;
  localparam logic [7:0]  PAD_CHAR        = 8'h3D;
  localparam logic [2:0]  LAST_PHASE      = 3'd4;

  function automatic logic [7:0] sym_to_char(input logic [4:0] sym);
    logic [7:0] ch;
    if (sym < 5'd26) begin
      ch = 8'h41 + {3'b000, sym};
    end else begin
      ch = 8'h32 + {3'b000, sym - 5'd26};
    end
    return ch;
  endfunction

  // Number of '=' characters after a final byte, by the group phase of that byte.
  function automatic logic [2:0] pad_by_phase(input logic [2:0] phase);
    logic [2:0] n;
    case (phase)
      3'd0: n = 3'd6;
      3'd1: n = 3'd4;
      3'd2: n = 3'd3;
      3'd3: n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== sv/base32_stream_encoder_unit.sv =====
// Streaming Base32 encoder, standard alphabet, '=' padding to eight characters.
// Each byte becomes a command in the command queue, then characters in the output register.
// Throughput: one character per cycle while char_stall is low, set by the single output
// register; a byte gives one or two characters, a final byte up to eight with flush and padding.
// A two-entry command queue lets bytes be taken while characters are stalled.
// Synchronous reset clears the bit carry, group phase, queue and output valid.
module base32_stream_encoder_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  b32e_pkg::byte_item_t byte_item,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b32e_pkg::char_item_t char_item
);

  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_not_empty;
  b32e_pkg::cmd_t front_cmd;
  b32e_pkg::cmd_t head_cmd;

  assign byte_stall = queue_full;

  b32e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  b32e_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head_cmd)
  );

  b32e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (queue_not_empty),
    .cmd        (head_cmd),
    .pop        (pop),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

endmodule

// ===== sv/b32e_front.sv =====
// Front end of the Base32 encoder: accepts bytes, keeps the bit carry and
// group phase, and turns each byte into a command. Depends on b32e_pkg.
module b32e_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  input  b32e_pkg::byte_item_t byte_item,
  input  logic                queue_full,
  output logic                push,
  output b32e_pkg::cmd_t      cmd
);

  logic [3:0] leftover_bits;
  logic [2:0] leftover_count;
  logic [2:0] group_phase;

  logic [11:0] acc;
  logic [2:0]  rem_count;
  logic [3:0]  rem_bits;
  logic [7:0]  flush_wide;
  logic [2:0]  pad_cnt;
  logic [3:0]  total;
  logic [2:0]  cnt_in;

  assign push = byte_valid && !queue_full;

  always_comb begin
    cnt_in = (leftover_count > 3'd4) ? 3'd4 : leftover_count;
    acc    = {leftover_bits, byte_item.data_byte};
    cmd.two_syms = (cnt_in >= 3'd2);
    cmd.sym0     = 5'(acc >> (cnt_in + 3'd3));
    cmd.sym1     = 5'(acc >> (cnt_in - 3'd2));
    rem_count    = cmd.two_syms ? (cnt_in - 3'd2) : (cnt_in + 3'd3);
    rem_bits     = acc[3:0] & 4'((5'd1 << rem_count) - 5'd1);
    // Leftover bits go to the top of the flush symbol, zero filled on the right.
    flush_wide   = {4'b0000, rem_bits} << (3'd5 - rem_count);
    cmd.flush_sym = flush_wide[4:0];
    cmd.msg_end   = byte_item.last_byte;
    cmd.has_flush = byte_item.last_byte && (rem_count != 3'd0);
    pad_cnt       = byte_item.last_byte ? b32e_pkg::pad_by_phase(group_phase) : 3'd0;
    total         = 4'd1 + {3'b000, cmd.two_syms} + {3'b000, cmd.has_flush}
                    + {1'b0, pad_cnt};
    cmd.last_idx  = 3'(total - 4'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= '0;
      leftover_count <= '0;
      group_phase    <= '0;
    end else if (push) begin
      if (byte_item.last_byte) begin
        leftover_bits  <= '0;
        leftover_count <= '0;
        group_phase    <= '0;
      end else begin
        leftover_bits  <= rem_bits;
        leftover_count <= rem_count;
        group_phase    <= (group_phase >= b32e_pkg::LAST_PHASE) ? 3'd0
                          : group_phase + 3'd1;
      end
    end
  end

endmodule

// ===== sv/b32e_cmd_queue.sv =====
// Short command queue between the front and back ends of the Base32 encoder.
// Depends on b32e_pkg for the command type and depth.
module b32e_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  b32e_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output b32e_pkg::cmd_t head
);

  localparam int unsigned PtrW = (b32e_pkg::CMD_QUEUE_DEPTH > 1)
                                 ? $clog2(b32e_pkg::CMD_QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(b32e_pkg::CMD_QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(b32e_pkg::CMD_QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(b32e_pkg::CMD_QUEUE_DEPTH);

  b32e_pkg::cmd_t entries [b32e_pkg::CMD_QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = (fill == Depth);
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b32e_back.sv =====
// Back end of the Base32 encoder: steps through the characters of the head
// command, one per cycle while not stalled, into the output register. Depends on b32e_pkg.
module b32e_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  b32e_pkg::cmd_t       cmd,
  output logic                 pop,
  output logic                 char_valid,
  input  logic                 char_stall,
  output b32e_pkg::char_item_t char_item
);

  logic [2:0] char_idx;
  logic       load;
  logic       emit;
  logic [2:0] flush_idx;
  b32e_pkg::char_item_t char_item_next;

  // The output register takes a new character whenever its current one leaves.
  assign load = !char_valid || !char_stall;
  assign emit = load && cmd_valid;
  assign pop  = emit && (char_idx == cmd.last_idx);

  always_comb begin
    flush_idx = cmd.two_syms ? 3'd2 : 3'd1;
    if (char_idx == 3'd0) begin
      char_item_next.out_char = b32e_pkg::sym_to_char(cmd.sym0);
    end else if (char_idx == 3'd1 && cmd.two_syms) begin
      char_item_next.out_char = b32e_pkg::sym_to_char(cmd.sym1);
    end else if (char_idx == flush_idx && cmd.has_flush) begin
      char_item_next.out_char = b32e_pkg::sym_to_char(cmd.flush_sym);
    end else begin
      char_item_next.out_char = b32e_pkg::PAD_CHAR;
    end
    char_item_next.last_char = cmd.msg_end && (char_idx == cmd.last_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      char_idx   <= '0;
    end else begin
      if (load) begin
        char_valid <= cmd_valid;
      end
      if (pop) begin
        char_idx <= '0;
      end else if (emit) begin
        char_idx <= char_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_item <= char_item_next;
    end
  end

endmodule

// ===== bench/base32_stream_encoder_unit_tb.sv =====
// Self-checking testbench for base32_stream_encoder_unit: directed and random messages,
// each character checked against a behavioural encoder under random bursts and stalls.
// Depends on b32e_pkg for the payload structs and the pad character.
module base32_stream_encoder_unit_tb;

  localparam int unsigned  CYCLE_LIMIT   = 200000;
  localparam int unsigned  TARGET_BYTES  = 470;
  localparam int unsigned  DRAIN_CYCLES  = 12;
  localparam int unsigned  MAX_REPORTS   = 40;
  localparam logic [255:0] B32_ALPHABET  = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 byte_valid = 1'b0;
  logic                 byte_stall;
  b32e_pkg::byte_item_t byte_item  = '0;
  logic                 char_valid;
  logic                 char_stall = 1'b0;
  b32e_pkg::char_item_t char_item;

  // Encoder state as seen by the predictor.
  logic [3:0] carry_bits  = '0;
  logic [2:0] carry_count = '0;
  logic [2:0] byte_phase  = '0;

  b32e_pkg::char_item_t expected_chars[$];
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned burst_left     = 0;
  bit          sender_gaps_on = 1'b1;
  stall_mode_t stall_mode     = STALL_NONE;
  int unsigned stall_left     = 0;

  base32_stream_encoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_item  (char_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d characters outstanding",
             cycle_count, expected_chars.size());
    $display("base32_stream_encoder_unit_tb: FAIL");
    $finish;
  end

  // The receiver switches at random between four stall modes.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     char_stall <= 1'b0;
      STALL_LIGHT:    char_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    char_stall <= ($urandom_range(0, 3) != 0);
      default:        char_stall <= ((stall_left % 3) == 0);
    endcase
  end

  function automatic logic [7:0] symbol_char(input logic [4:0] sym);
    return B32_ALPHABET[8 * (31 - sym) +: 8];
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    if (error_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s expected %02h got %02h",
               cycle_count, what, want, got);
    end
    error_count++;
  endtask

  // Works out the characters one accepted byte causes and queues them.
  task automatic predict_characters(input b32e_pkg::byte_item_t item);
    logic [11:0] acc;
    logic [11:0] sym_word;
    logic [7:0]  chars [0:7];
    int unsigned nbits;
    int unsigned n;
    int unsigned pads;
    b32e_pkg::char_item_t result;
    acc   = {carry_bits, item.data_byte};
    nbits = carry_count + 8;
    n     = 0;
    while (nbits >= 5) begin
      nbits    = nbits - 5;
      sym_word = acc >> nbits;
      chars[n] = symbol_char(sym_word[4:0]);
      n        = n + 1;
    end
    acc = acc & ((12'd1 << nbits) - 12'd1);
    if (!item.last_byte) begin
      carry_bits  = acc[3:0];
      carry_count = nbits[2:0];
      byte_phase  = (byte_phase >= 3'd4) ? 3'd0 : byte_phase + 3'd1;
    end else begin
      if (nbits > 0) begin
        sym_word = acc << (5 - nbits);
        chars[n] = symbol_char(sym_word[4:0]);
        n        = n + 1;
      end
      case (byte_phase)
        3'd0:    pads = 6;
        3'd1:    pads = 4;
        3'd2:    pads = 3;
        3'd3:    pads = 1;
        default: pads = 0;
      endcase
      repeat (pads) begin
        chars[n] = b32e_pkg::PAD_CHAR;
        n        = n + 1;
      end
      carry_bits  = '0;
      carry_count = '0;
      byte_phase  = '0;
    end
    for (int unsigned i = 0; i < n; i++) begin
      result.out_char  = chars[i];
      result.last_char = item.last_byte && (i == n - 1);
      expected_chars.push_back(result);
    end
  endtask

  // Both channels are sampled at the edge, before any of that edge's updates land.
  always @(posedge clk) begin
    b32e_pkg::char_item_t want;
    if (!rst && char_valid && !char_stall) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected character", 8'h00, char_item.out_char);
      end else begin
        want = expected_chars.pop_front();
        if (char_item.out_char !== want.out_char) begin
          report_mismatch("out_char", want.out_char, char_item.out_char);
        end
        if (char_item.last_char !== want.last_char) begin
          report_mismatch("last_char", {7'd0, want.last_char}, {7'd0, char_item.last_char});
        end
      end
    end
    if (!rst && byte_valid && !byte_stall) begin
      predict_characters(byte_item);
    end
  end

  // Sends one byte as a transaction; the sender works in bursts with gaps between them.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (sender_gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left           = burst_left - 1;
    byte_valid          <= 1'b1;
    byte_item.data_byte <= data;
    byte_item.last_byte <= last;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_message(input int unsigned len, input logic [7:0] start,
                              input logic [7:0] stride);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'(start + i * stride), i == len - 1);
    end
  endtask

  // The extra edge lets the prediction for the last accepted byte land first.
  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  // One-byte messages: a flush character and six pad characters each.
  task automatic test_single_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b1);
  endtask

  // The final byte at the second to fifth positions of the five-byte group, the full group included.
  task automatic test_final_byte_phases();
    send_message(2, 8'hFF, 8'h81);
    send_message(3, 8'h00, 8'h55);
    send_message(4, 8'h80, 8'h3B);
    send_message(5, 8'hFF, 8'h00);
  endtask

  // A message longer than one group, followed straight away by a fresh one.
  task automatic test_back_to_back_messages();
    send_message(6, 8'h01, 8'h7F);
    send_message(1, 8'h7E, 8'h00);
  endtask

  // The sender stops mid-message until every expected character has come out.
  task automatic test_pause_mid_message();
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h99, 1'b0);
    wait_for_drain();
    send_byte(8'h66, 1'b0);
    send_byte(8'h0F, 1'b1);
    wait_for_drain();
  endtask

  // Random messages, mostly short, some longer and some with extreme bytes.
  task automatic test_random_messages();
    int unsigned len;
    logic [7:0]  data;
    while (bytes_sent < TARGET_BYTES) begin
      // A stretch with no sender gaps now and then.
      sender_gaps_on = ($urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 32) : $urandom_range(1, 10);
      for (int unsigned i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom_range(0, 255));
        endcase
        send_byte(data, i == len - 1);
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_for_drain();
      end
    end
    sender_gaps_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_single_byte_messages();
    test_final_byte_phases();
    test_back_to_back_messages();
    test_pause_mid_message();
    test_random_messages();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("base32_stream_encoder_unit_tb: PASS");
    end else begin
      $display("base32_stream_encoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
